[sv/bnfa_pkg.sv]
package bnfa_pkg;

	localparam int MAX_SLOTS_DEFAULT = 64;
	localparam int SLOT_W            = 6;
	localparam int COUNT_W           = 7;
	localparam int STRIDE_W          = 16;
	localparam int ADDR_W            = 64;
	localparam int CFG_INDEX_W       = 4;
	localparam int CFG_DATA_W        = 64;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_BAD_SLOT  = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_SLOT_COUNT  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOT_STRIDE = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CPU_BASE    = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_GPU_BASE    = 4'd3;

	localparam logic [COUNT_W-1:0]  SLOT_COUNT_RESET  = 7'd64;
	localparam logic [STRIDE_W-1:0] SLOT_STRIDE_RESET = 16'd32;

	typedef struct packed {
		logic              op;
		logic [SLOT_W-1:0] release_slot;
	} in_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] granted_slot;
		logic [ADDR_W-1:0] cpu_address;
		logic [ADDR_W-1:0] gpu_address;
		logic [1:0]        status;
		logic              now_full;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic cfg_write;
	} dp_cmd_t;

endpackage

[sv/bnfa_ctrl.sv]
module bnfa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	output bnfa_pkg::dp_cmd_t cmd
);
	import bnfa_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   exec;

	// exec only when the output register is free or being emptied
	assign exec      = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	assign cmd.load      = in_valid && in_ready;
	assign cmd.exec      = exec;
	assign cmd.cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[sv/bnfa_dp.sv]
module bnfa_dp #(
	parameter int MAX_SLOTS = bnfa_pkg::MAX_SLOTS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bnfa_pkg::dp_cmd_t                    cmd,
	input  bnfa_pkg::in_item_t                   in_data,
	input  logic [bnfa_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bnfa_pkg::CFG_DATA_W-1:0]      cfg_data,
	output bnfa_pkg::out_item_t                  out_data
);
	import bnfa_pkg::*;

	localparam int SLOT_LIMIT = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;
	localparam logic [COUNT_W-1:0] LIMIT_N = COUNT_W'(SLOT_LIMIT);
	localparam logic [COUNT_W-1:0] MIN_N   = 7'd8;

	logic [COUNT_W-1:0]    slot_count_q;
	logic [STRIDE_W-1:0]   stride_q;
	logic [ADDR_W-1:0]     cpu_base_q;
	logic [ADDR_W-1:0]     gpu_base_q;
	logic [SLOT_LIMIT-1:0] occ_q;
	logic [SLOT_W-1:0]     cursor_q;
	logic                  full_q;
	in_item_t              item_q;
	out_item_t             out_q;

	logic [COUNT_W-1:0]    count_masked;
	logic [COUNT_W-1:0]    n_active;
	logic [SLOT_LIMIT-1:0] in_range;
	logic [SLOT_LIMIT-1:0] cur_hit;
	logic [SLOT_LIMIT-1:0] rel_hit;
	logic [SLOT_LIMIT-1:0] above_cur;
	logic [SLOT_LIMIT-1:0] occ_alloc;
	logic [SLOT_LIMIT-1:0] free_vec;
	logic [SLOT_LIMIT-1:0] free_hi;
	logic [SLOT_W-1:0]     first_hi;
	logic [SLOT_W-1:0]     first_any;
	logic                  any_free;
	logic                  any_hi;
	logic                  rel_bad;
	logic [SLOT_W+STRIDE_W-1:0] offset;
	logic [ADDR_W-1:0]     cpu_addr;
	logic [ADDR_W-1:0]     gpu_addr;

	// effective slot count: multiple of eight, clamped to 8 .. slot limit
	assign count_masked = slot_count_q & 7'h78;
	always_comb begin
		priority if (count_masked < MIN_N) begin
			n_active = MIN_N;
		end else if (count_masked > LIMIT_N) begin
			n_active = LIMIT_N;
		end else begin
			n_active = count_masked;
		end
	end

	always_comb begin
		for (int i = 0; i < SLOT_LIMIT; i++) begin
			in_range[i]  = (COUNT_W'(i) < n_active);
			cur_hit[i]   = (SLOT_W'(i) == cursor_q);
			rel_hit[i]   = (SLOT_W'(i) == item_q.release_slot);
			above_cur[i] = (SLOT_W'(i) > cursor_q);
		end
	end

	assign occ_alloc = occ_q | cur_hit;
	assign free_vec  = ~occ_alloc & in_range;
	assign free_hi   = free_vec & above_cur;
	assign any_free  = |free_vec;
	assign any_hi    = |free_hi;

	// lowest free slot past the cursor, else lowest free slot from zero
	always_comb begin
		first_hi  = '0;
		first_any = '0;
		for (int i = SLOT_LIMIT - 1; i >= 0; i--) begin
			if (free_hi[i]) begin
				first_hi = SLOT_W'(i);
			end
			if (free_vec[i]) begin
				first_any = SLOT_W'(i);
			end
		end
	end

	assign rel_bad  = ({1'b0, item_q.release_slot} >= n_active);
	assign offset   = (SLOT_W+STRIDE_W)'(cursor_q) * (SLOT_W+STRIDE_W)'(stride_q);
	assign cpu_addr = cpu_base_q + ADDR_W'(offset);
	assign gpu_addr = gpu_base_q + ADDR_W'(offset);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RESET;
			stride_q     <= SLOT_STRIDE_RESET;
			cpu_base_q   <= '0;
			gpu_base_q   <= '0;
			occ_q        <= '0;
			cursor_q     <= '0;
			full_q       <= 1'b0;
		end else begin
			if (cmd.cfg_write) begin
				unique case (cfg_index)
					REG_SLOT_COUNT: begin
						slot_count_q <= cfg_data[COUNT_W-1:0];
						occ_q        <= '0;
						cursor_q     <= '0;
						full_q       <= 1'b0;
					end
					REG_SLOT_STRIDE: begin
						stride_q <= cfg_data[STRIDE_W-1:0];
					end
					REG_CPU_BASE: begin
						cpu_base_q <= cfg_data;
					end
					REG_GPU_BASE: begin
						gpu_base_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end else if (cmd.exec) begin
				if (item_q.op == OP_ALLOC) begin
					if (!full_q) begin
						occ_q <= occ_alloc;
						if (any_free) begin
							cursor_q <= any_hi ? first_hi : first_any;
						end else begin
							full_q <= 1'b1;
						end
					end
				end else if (!rel_bad) begin
					occ_q <= occ_q & ~rel_hit;
					if (full_q) begin
						full_q   <= 1'b0;
						cursor_q <= item_q.release_slot;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.exec) begin
			out_q.granted_slot <= '0;
			out_q.cpu_address  <= '0;
			out_q.gpu_address  <= '0;
			out_q.status       <= STATUS_OK;
			out_q.now_full     <= full_q;
			if (item_q.op == OP_ALLOC) begin
				if (full_q) begin
					out_q.status <= STATUS_FULL;
				end else begin
					out_q.granted_slot <= cursor_q;
					out_q.cpu_address  <= cpu_addr;
					out_q.gpu_address  <= gpu_addr;
					out_q.now_full     <= !any_free;
				end
			end else if (rel_bad) begin
				out_q.status <= STATUS_BAD_SLOT;
			end else begin
				out_q.now_full <= 1'b0;
			end
		end
	end

	assign out_data = out_q;

endmodule

[sv/bitmap_next_fit_slot_allocator.sv]
// the result is registered when exec fires, which waits while an earlier result is held
// one item at a time, as in_ready is low in exec; the exec cycle does the bitmap search
// (rotate-style masked priority encode over the occupancy bits) and the address multiply-add
// a waiting result does not block configuration writes
// reset: config registers to defaults, occupancy bitmap, cursor and full flag cleared at once
module bitmap_next_fit_slot_allocator #(
	parameter int MAX_SLOTS = bnfa_pkg::MAX_SLOTS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  bnfa_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output bnfa_pkg::out_item_t              out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bnfa_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bnfa_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bnfa_pkg::*;

	dp_cmd_t cmd;

	bnfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	bnfa_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import bnfa_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 150;
	localparam int SETTLE_CYCLES  = 6;
	localparam int PHASE_ITEMS    = 111;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 4'hF;
	localparam int PHASE_COUNTS [12] = '{0, 64, 7, 16, 24, 65, 32, 40, 8, 56, 48, 127};

	class slot_grant_tracker;
		logic [63:0]         used;
		logic [SLOT_W-1:0]   cursor;
		logic                full;
		logic [COUNT_W-1:0]  count_reg;
		logic [STRIDE_W-1:0] stride;
		logic [ADDR_W-1:0]   cpu_base;
		logic [ADDR_W-1:0]   gpu_base;
		out_item_t           pending_grants[$];
		int errors, grants, refusals, releases, bad_releases;

		function new();
			count_reg = SLOT_COUNT_RESET;
			stride = SLOT_STRIDE_RESET;
			cpu_base = '0;
			gpu_base = '0;
			clear_pool();
		endfunction

		function void clear_pool();
			used = '0;
			cursor = '0;
			full = 1'b0;
		endfunction

		// slot_count rounds down to a multiple of eight, clamped to 8..64
		function int live_slots();
			int n;
			n = int'(count_reg & 7'h78);
			if (n < 8)
				n = 8;
			if (n > MAX_SLOTS_DEFAULT)
				n = MAX_SLOTS_DEFAULT;
			return n;
		endfunction

		function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SLOT_COUNT: begin
					count_reg = data[COUNT_W-1:0];
					clear_pool();
				end
				REG_SLOT_STRIDE: stride = data[STRIDE_W-1:0];
				REG_CPU_BASE: cpu_base = data;
				REG_GPU_BASE: gpu_base = data;
				default: ;
			endcase
		endfunction

		function void note_request(in_item_t req);
			out_item_t want;
			int n, cur, hop;
			bit found;
			n = live_slots();
			want = '0;
			want.status = STATUS_OK;
			if (req.op == OP_ALLOC) begin
				if (full) begin
					want.status = STATUS_FULL;
					refusals++;
				end else begin
					cur = int'(cursor) % n;
					used[cur] = 1'b1;
					want.granted_slot = cur[SLOT_W-1:0];
					want.cpu_address = cpu_base + ADDR_W'(cur) * ADDR_W'(stride);
					want.gpu_address = gpu_base + ADDR_W'(cur) * ADDR_W'(stride);
					// circular search starting just past the granted slot
					found = 1'b0;
					for (hop = 0; hop < n && !found; hop++) begin
						cur = (cur + 1) % n;
						found = !used[cur];
					end
					cursor = cur[SLOT_W-1:0];
					if (!found)
						full = 1'b1;
					grants++;
				end
			end else if (int'(req.release_slot) >= n) begin
				want.status = STATUS_BAD_SLOT;
				bad_releases++;
			end else begin
				used[req.release_slot] = 1'b0;
				if (full) begin
					full = 1'b0;
					cursor = req.release_slot;
				end
				releases++;
			end
			want.now_full = full;
			pending_grants.insert(pending_grants.size(), want);
		endfunction

		function void report_field(string field, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_grant(out_item_t got);
			out_item_t want;
			if (pending_grants.size() == 0) begin
				$display("%0t: result with nothing expected: %h", $time, got);
				errors++;
				return;
			end
			want = pending_grants.pop_front();
			report_field("granted_slot", 64'(want.granted_slot), 64'(got.granted_slot));
			report_field("cpu_address", want.cpu_address, got.cpu_address);
			report_field("gpu_address", want.gpu_address, got.gpu_address);
			report_field("status", 64'(want.status), 64'(got.status));
			report_field("now_full", 64'(want.now_full), 64'(got.now_full));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	in_item_t               in_data;
	logic                   out_valid;
	logic                   out_ready;
	out_item_t              out_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	slot_grant_tracker tracker;
	bit hold_request = 1'b0;
	int quiet_cycles = 0;
	int phase_count = 0;

	bitmap_next_fit_slot_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (in_valid && in_ready)
			tracker.note_request(in_data);
		if (out_valid && out_ready)
			tracker.check_grant(out_data);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("bitmap_next_fit_slot_allocator regression: fail");
			$finish;
		end
	end

	// result side: mostly short runs of ready, some long runs of ready, short stalls and rare long stalls
	initial begin
		int left;
		int r;
		bit lvl;
		left = 0;
		lvl = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				lvl = 1'b0;
				left = HOLD_CYCLES;
			end else if (left == 0) begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					lvl = 1'b1;
					left = $urandom_range(1, 6);
				end else if (r < 75) begin
					lvl = 1'b1;
					left = $urandom_range(20, 80);
				end else if (r < 95) begin
					lvl = 1'b0;
					left = $urandom_range(1, 3);
				end else begin
					lvl = 1'b0;
					left = $urandom_range(10, 60);
				end
			end
			out_ready <= lvl;
			left--;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_request(in_item_t req, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_grants.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_register(idx, data);
	endtask

	// config is only touched once the block has gone quiet
	task automatic configure(logic [63:0] count, logic [63:0] stride, logic [63:0] cpu,
			logic [63:0] gpu, bit poke_unused);
		drain();
		if (poke_unused)
			write_reg(REG_UNUSED, {$urandom, $urandom});
		write_reg(REG_SLOT_COUNT, count);
		write_reg(REG_SLOT_STRIDE, stride);
		write_reg(REG_CPU_BASE, cpu);
		write_reg(REG_GPU_BASE, gpu);
		cfg_valid <= 1'b0;
		phase_count++;
	endtask

	// mostly allocations and releases of slots in use, the rest arbitrary releases
	function automatic in_item_t random_request(int alloc_pct);
		in_item_t req;
		int n, r, start, k;
		n = tracker.live_slots();
		r = $urandom_range(0, 99);
		req.op = OP_RELEASE;
		req.release_slot = SLOT_W'($urandom_range(0, 63));
		if (r < alloc_pct) begin
			req.op = OP_ALLOC;
		end else if (r < alloc_pct + (100 - alloc_pct) * 3 / 4) begin
			start = $urandom_range(0, n - 1);
			for (k = 0; k < n; k++) begin
				if (tracker.used[(start + k) % n]) begin
					req.release_slot = SLOT_W'((start + k) % n);
					break;
				end
			end
		end
		return req;
	endfunction

	task automatic run_phase(int items, int alloc_pct, bit squeeze);
		bit steady;
		steady = ($urandom_range(0, 3) == 0);
		for (int k = 0; k < items; k++) begin
			if (squeeze && k == 10)
				hold_request = 1'b1;
			send_request(random_request(alloc_pct), (steady || squeeze) ? 0 : pick_gap());
		end
	endtask

	initial begin
		logic [63:0] count, stride, cpu, gpu;
		int p;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tracker = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// eight slots: fill, refuse while full, bad releases, release while full
		configure(64'd8, 64'hFFFF, 64'hFFFF_FFFF_FFFF_FFF0, 64'h8000_0000_0000_0001, 1'b1);
		send_request(in_item_t'{OP_ALLOC, 6'h3F}, 0);
		repeat (7) send_request(in_item_t'{OP_ALLOC, 6'h00}, 0);
		send_request(in_item_t'{OP_ALLOC, 6'h15}, 1);
		send_request(in_item_t'{OP_RELEASE, 6'h3F}, 0);
		send_request(in_item_t'{OP_RELEASE, 6'd8}, 2);
		send_request(in_item_t'{OP_RELEASE, 6'd3}, 0);
		send_request(in_item_t'{OP_ALLOC, 6'h2A}, 0);
		send_request(in_item_t'{OP_RELEASE, 6'd7}, 0);
		send_request(in_item_t'{OP_RELEASE, 6'd0}, 0);
		send_request(in_item_t'{OP_RELEASE, 6'd0}, 3);
		send_request(in_item_t'{OP_ALLOC, 6'd0}, 0);
		send_request(in_item_t'{OP_ALLOC, 6'd0}, 0);

		// oversized count clamps to 64, zero stride
		configure(64'd127, 64'd0, 64'd0, '1, 1'b0);
		send_request(in_item_t'{OP_ALLOC, 6'd0}, 0);
		send_request(in_item_t'{OP_ALLOC, 6'd0}, 0);
		send_request(in_item_t'{OP_RELEASE, 6'd63}, 0);
		send_request(in_item_t'{OP_RELEASE, 6'd32}, 0);
		send_request(in_item_t'{OP_ALLOC, 6'd0}, 0);

		for (p = 0; p < 12; p++) begin
			count = ({$urandom, $urandom} & ~64'h7F) | 64'(PHASE_COUNTS[p]);
			stride = {$urandom, $urandom};
			case (p % 4)
				0: stride[15:0] = 16'h0000;
				1: stride[15:0] = 16'hFFFF;
				2: stride[15:0] = 16'h0001;
				default: ;
			endcase
			case (p % 3)
				0: begin
					cpu = '0;
					gpu = '1;
				end
				1: begin
					cpu = '1;
					gpu = '0;
				end
				default: begin
					cpu = {$urandom, $urandom};
					gpu = {$urandom, $urandom};
				end
			endcase
			configure(count, stride, cpu, gpu, p == 5);
			run_phase(PHASE_ITEMS, (tracker.live_slots() >= 48) ? 80 : 62, p == 2);
		end

		drain();
		$display("%0d configurations, slot counts 8 to 64: %0d grants, %0d refused when full,",
			phase_count, tracker.grants, tracker.refusals);
		$display("%0d releases, %0d out-of-range releases, %0d mismatches",
			tracker.releases, tracker.bad_releases, tracker.errors);
		if (tracker.errors == 0)
			$display("bitmap_next_fit_slot_allocator regression: pass");
		else
			$display("bitmap_next_fit_slot_allocator regression: fail");
		$finish;
	end

endmodule
